>>> hw/rtl/ssf_pkg.sv
`default_nettype none

package ssf_pkg;

    // Fixed geometry of the display.
    localparam int ROWS           = 3;
    localparam int DIGITS_DEFAULT = 6;
    localparam int TEXT_BYTES     = 6;
    localparam int FRAME_BYTES    = 5;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Segment constants, active low, bit 7 is the decimal point.
    localparam logic [7:0] BLANK_SEG = 8'hFF;
    localparam logic [7:0] SKIP_BYTE = 8'hFF;
    localparam logic [7:0] DP_CLEAR  = 8'h7F;

    // Reset value of the point position register: no point lit.
    localparam logic [2:0] POINT_RESET = 3'd7;

    // Frame byte numbers.
    localparam logic [2:0] BYTE_SKIP   = 3'd0;
    localparam logic [2:0] BYTE_ROW2   = 3'd1;
    localparam logic [2:0] BYTE_SELECT = 3'd2;
    localparam logic [2:0] BYTE_ROW1   = 3'd3;
    localparam logic [2:0] BYTE_ROW0   = 3'd4;

    // One encoded frame waiting to be shifted out; the skip byte is implied.
    typedef struct packed {
        logic [7:0] row2;
        logic [7:0] select;
        logic [7:0] row1;
        logic [7:0] row0;
    } frame_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // ASCII to segment pattern; anything unknown shows blank.
    function automatic logic [7:0] encode_char(input logic [7:0] c);
        logic [7:0] seg;
        unique case (c)
            8'h30:   seg = 8'hC0;
            8'h31:   seg = 8'hF9;
            8'h32:   seg = 8'hA4;
            8'h33:   seg = 8'hB0;
            8'h34:   seg = 8'h99;
            8'h35:   seg = 8'h92;
            8'h36:   seg = 8'h82;
            8'h37:   seg = 8'hF8;
            8'h38:   seg = 8'h80;
            8'h39:   seg = 8'h90;
            8'h4C:   seg = 8'hC7; // L
            8'h2E:   seg = 8'h7F; // .
            8'h54:   seg = 8'hF8; // T
            8'h4F:   seg = 8'hC0; // O
            8'h41:   seg = 8'h88; // A
            8'h53:   seg = 8'h92; // S
            8'h48:   seg = 8'h89; // H
            8'h49:   seg = 8'hCF; // I
            8'h46:   seg = 8'h8E; // F
            8'h47:   seg = 8'hC2; // G
            8'h50:   seg = 8'h8C; // P
            8'h43:   seg = 8'hB1; // C
            8'h45:   seg = 8'h86; // E
            8'h55:   seg = 8'hC1; // U
            8'h4E:   seg = 8'hC8; // N
            8'h52:   seg = 8'hCE; // R
            8'h44:   seg = 8'hA1; // D
            default: seg = BLANK_SEG;
        endcase
        return seg;
    endfunction

    // Power-up text: "123456", "654321" and "987654"; positions past six are NUL.
    function automatic logic [7:0] reset_char(input int r, input int k);
        logic [7:0] ch;
        if (k >= TEXT_BYTES) begin
            ch = 8'h00;
        end
        else if (r == 0) begin
            ch = 8'(49 + k);
        end
        else if (r == 1) begin
            ch = 8'(54 - k);
        end
        else begin
            ch = 8'(57 - k);
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssf_front.sv
`default_nettype none

module ssf_front
    import ssf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [1:0]  row,
    input  wire logic [2:0]  text_length,
    input  wire logic [47:0] text,
    input  q_status_t        q_status,
    output logic             push,
    output frame_t           push_frame
);

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [3:0] DIGITS_4 = 4'(DIGITS);
    localparam logic [2:0] LEN_RESET = 3'((DIGITS < 6) ? DIGITS : 6);

    logic [2:0] point_reg;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic [7:0] store_reg [ROWS][DIGITS];
    logic [2:0] len_reg [ROWS];

    logic       accept;
    logic       do_write;
    logic [2:0] len_sat;
    logic [7:0] text_byte [DIGITS];
    logic [7:0] seg [ROWS];
    logic       pos_ok;
    logic       point_hit;

    // Items are held off only while the queue has no room.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign do_write = accept && (command == CMD_WRITE) && (32'(row) < ROWS);
    assign push     = accept && (command == CMD_TICK);

    // Long texts are cut to the number of digits.
    assign len_sat = ({1'b0, text_length} > DIGITS_4) ? 3'(DIGITS) : text_length;

    // Split the text field into bytes; positions past the field read as NUL.
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++) begin
            if (k < TEXT_BYTES) begin
                text_byte[k] = text[(8 * k) % 48 +: 8];
            end
            else begin
                text_byte[k] = 8'h00;
            end
        end
    end

    // Row segments for the current scan position, right aligned.
    assign pos_ok = ({1'b0, pos_reg} < DIGITS_4);

    always_comb
    begin
        logic [3:0] idx;
        for (int r = 0; r < ROWS; r++) begin
            idx = {1'b0, len_reg[r]} - 4'd1 - {1'b0, pos_reg};
            if (pos_ok && (pos_reg < len_reg[r])) begin
                seg[r] = encode_char(store_reg[r][idx[IDX_W-1:0]]);
            end
            else begin
                seg[r] = BLANK_SEG;
            end
        end
    end

    assign point_hit = pos_ok && ({1'b0, point_reg} < DIGITS_4) && (pos_reg == point_reg);

    // Assemble the frame that goes into the queue.
    always_comb
    begin
        push_frame.row2   = seg[2];
        push_frame.select = pos_ok ? ~(8'd1 << pos_reg) : BLANK_SEG;
        push_frame.row1   = point_hit ? (seg[1] & DP_CLEAR) : seg[1];
        push_frame.row0   = seg[0];
    end

    // Next scan position wraps after the last digit.
    assign pos_next = (({1'b0, pos_reg} + 4'd1) >= DIGITS_4) ? 3'd0 : (pos_reg + 3'd1);

    // Configuration, scan position, row text and lengths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            point_reg <= POINT_RESET;
            pos_reg   <= 3'd0;
            for (int r = 0; r < ROWS; r++) begin
                len_reg[r] <= LEN_RESET;
                for (int k = 0; k < DIGITS; k++) begin
                    store_reg[r][k] <= reset_char(r, k);
                end
            end
        end
        else begin
            if (cfg_wr_en) begin
                point_reg <= cfg_wr_data;
            end
            if (push) begin
                pos_reg <= pos_next;
            end
            if (do_write) begin
                len_reg[row] <= len_sat;
                for (int k = 0; k < DIGITS; k++) begin
                    store_reg[row][k] <= text_byte[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ssf_queue.sv
`default_nettype none

module ssf_queue
    import ssf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  frame_t    push_frame,
    input  wire logic pop,
    output frame_t    head_frame,
    output q_status_t status
);

    frame_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head_frame   = mem_reg[rd_ptr_reg];

    // Frame storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // A full queue never takes a frame and an empty one never gives one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count did not follow a write");

endmodule

`default_nettype wire

>>> hw/rtl/ssf_back.sv
`default_nettype none

module ssf_back
    import ssf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  frame_t     head_frame,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [7:0] frame_byte,
    output logic [2:0] byte_number,
    output logic       last_byte
);

    logic       busy_reg;
    logic [2:0] idx_reg;
    frame_t     cur_reg;
    logic       xfer;
    logic       done;

    assign out_valid   = busy_reg;
    assign byte_number = idx_reg;
    assign last_byte   = (idx_reg == BYTE_ROW0);
    assign xfer        = busy_reg && !out_stall;
    assign done        = xfer && last_byte;

    // A new frame is taken when idle or right as the last byte leaves.
    assign pop = (!busy_reg || done) && !q_status.empty;

    // Pick the byte of the held frame.
    always_comb
    begin
        unique case (idx_reg)
            BYTE_SKIP:   frame_byte = SKIP_BYTE;
            BYTE_ROW2:   frame_byte = cur_reg.row2;
            BYTE_SELECT: frame_byte = cur_reg.select;
            BYTE_ROW1:   frame_byte = cur_reg.row1;
            BYTE_ROW0:   frame_byte = cur_reg.row0;
            default:     frame_byte = BLANK_SEG;
        endcase
    end

    // Held frame.
    always_ff @(posedge clk)
    begin
        if (pop) begin
            cur_reg <= head_frame;
        end
    end

    // Byte sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= BYTE_SKIP;
        end
        else begin
            if (pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= BYTE_SKIP;
            end
            else if (done) begin
                busy_reg <= 1'b0;
                idx_reg  <= BYTE_SKIP;
            end
            else if (xfer) begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // A frame is never cut short and the byte count stays inside the frame.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= BYTE_ROW0))
        else $error("byte number out of frame");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (busy_reg && (idx_reg == BYTE_SKIP)))
        else $error("new frame did not start at the skip byte");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && q_status.empty) |=> !busy_reg)
        else $error("output still valid after the final byte");

endmodule

`default_nettype wire

>>> hw/rtl/seven_segment_scan_framer_top.sv
// A scan tick's frame is written into the queue at its transfer; when the output side
// is idle it is then loaded into the serializer, which offers its first frame byte.
// A write takes effect at its transfer edge.
// The output serializer sends one frame byte per cycle while out_stall is low; a
// two-frame queue lets input transfers continue meanwhile.
// Reset (rst_n, asynchronous, active low) restores the power-up text, full lengths,
// scan position zero and no decimal point, and empties the queue.
`default_nettype none

module seven_segment_scan_framer_top
    import ssf_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [1:0]  row,
    input  wire logic [2:0]  text_length,
    input  wire logic [47:0] text,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_byte,
    output logic [2:0]       byte_number,
    output logic             last_byte
);

    q_status_t q_status;
    frame_t    push_frame;
    frame_t    head_frame;
    logic      push;
    logic      pop;

    // Front: takes items, keeps the text and encodes each tick into a frame.
    ssf_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .row         (row),
        .text_length (text_length),
        .text        (text),
        .q_status    (q_status),
        .push        (push),
        .push_frame  (push_frame)
    );

    // Queue of encoded frames.
    ssf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .status     (q_status)
    );

    // Back: shifts each frame out one byte per transfer.
    ssf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_frame  (head_frame),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .byte_number (byte_number),
        .last_byte   (last_byte)
    );

endmodule

`default_nettype wire

>>> tb/seven_segment_scan_framer_top_test.sv
`timescale 1ns / 1ps

module seven_segment_scan_framer_top_test;
    import ssf_pkg::*;

    localparam int DIGITS      = DIGITS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 4;
    localparam int TAIL_CYCLES = 20;

    // One frame byte as it should leave the block.
    typedef struct packed {
        logic [7:0] seg;
        logic [2:0] num;
        logic       last_flag;
    } frame_byte_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_wr_data = 3'd0;
    logic        in_valid    = 1'b0;
    logic        command     = CMD_WRITE;
    logic [1:0]  row         = 2'd0;
    logic [2:0]  text_length = 3'd0;
    logic [47:0] text        = 48'd0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  frame_byte;
    logic [2:0]  byte_number;
    logic        last_byte;

    // Display state kept by the testbench.
    logic [2:0]  model_point = POINT_RESET;
    logic [2:0]  model_scan;
    logic [7:0]  model_text [ROWS][DIGITS];
    logic [2:0]  model_len [ROWS];
    frame_byte_t pending_frame_bytes [$];

    string power_up [ROWS] = '{"123456", "654321", "987654"};
    string charset = "0123456789L.TOASHIFGPCEUNRD";

    int error_count    = 0;
    int ticks_sent     = 0;
    int writes_sent    = 0;
    int bytes_checked  = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    always #6 clk = ~clk;

    seven_segment_scan_framer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .row         (row),
        .text_length (text_length),
        .text        (text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .byte_number (byte_number),
        .last_byte   (last_byte)
    );

    // Segment pattern of one ASCII character, active low, blank when unknown.
    function automatic logic [7:0] segment_for_char(input logic [7:0] ch);
        case (ch)
            8'h30: return 8'hC0;
            8'h31: return 8'hF9;
            8'h32: return 8'hA4;
            8'h33: return 8'hB0;
            8'h34: return 8'h99;
            8'h35: return 8'h92;
            8'h36: return 8'h82;
            8'h37: return 8'hF8;
            8'h38: return 8'h80;
            8'h39: return 8'h90;
            8'h4C: return 8'hC7; // L
            8'h2E: return 8'h7F; // .
            8'h54: return 8'hF8; // T
            8'h4F: return 8'hC0; // O
            8'h41: return 8'h88; // A
            8'h53: return 8'h92; // S
            8'h48: return 8'h89; // H
            8'h49: return 8'hCF; // I
            8'h46: return 8'h8E; // F
            8'h47: return 8'hC2; // G
            8'h50: return 8'h8C; // P
            8'h43: return 8'hB1; // C
            8'h45: return 8'h86; // E
            8'h55: return 8'hC1; // U
            8'h4E: return 8'hC8; // N
            8'h52: return 8'hCE; // R
            8'h44: return 8'hA1; // D
            default: return BLANK_SEG;
        endcase
    endfunction

    // Segments a row shows at one digit position; text is right aligned.
    function automatic logic [7:0] row_digit_segments(input int r, input int pos);
        int len;
        len = model_len[r];
        if (pos >= DIGITS || pos >= len) return BLANK_SEG;
        return segment_for_char(model_text[r][len - 1 - pos]);
    endfunction

    // Update the display state for one transfer and queue any frame it causes.
    function automatic void apply_display_item(input logic cmd, input logic [1:0] r,
                                               input logic [2:0] len, input logic [47:0] txt);
        int pos;
        logic [7:0] select_seg;
        logic [7:0] middle_seg;
        if (cmd == CMD_WRITE) begin
            if (r < ROWS) begin
                for (int k = 0; k < DIGITS; k++)
                    model_text[r][k] = (k < TEXT_BYTES) ? txt[8*k +: 8] : 8'h00;
                model_len[r] = (len > DIGITS) ? 3'(DIGITS) : len;
            end
            return;
        end
        pos = model_scan;
        select_seg = (pos < DIGITS) ? ~(8'd1 << pos) : BLANK_SEG;
        middle_seg = row_digit_segments(1, pos);
        if (pos < DIGITS && model_point < DIGITS && pos == model_point)
            middle_seg = middle_seg & DP_CLEAR;
        pending_frame_bytes.push_back('{SKIP_BYTE, BYTE_SKIP, 1'b0});
        pending_frame_bytes.push_back('{row_digit_segments(2, pos), BYTE_ROW2, 1'b0});
        pending_frame_bytes.push_back('{select_seg, BYTE_SELECT, 1'b0});
        pending_frame_bytes.push_back('{middle_seg, BYTE_ROW1, 1'b0});
        pending_frame_bytes.push_back('{row_digit_segments(0, pos), BYTE_ROW0, 1'b1});
        model_scan = (pos + 1 >= DIGITS) ? 3'd0 : 3'(pos + 1);
    endfunction

    // Track every input transfer.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            if (command == CMD_TICK)
                ticks_sent++;
            else
                writes_sent++;
            apply_display_item(command, row, text_length, text);
        end
    end

    // Compare every output transfer with the oldest pending frame byte.
    always @(posedge clk)
    begin : check_output
        frame_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frame_bytes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected frame byte: expected none, actual %02h/%0d/%0b",
                         $time, frame_byte, byte_number, last_byte);
            end
            else
            begin
                want = pending_frame_bytes.pop_front();
                bytes_checked++;
                if (frame_byte !== want.seg)
                begin
                    error_count++;
                    $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                             $time, want.seg, frame_byte);
                end
                if (byte_number !== want.num)
                begin
                    error_count++;
                    $display("%0t: byte_number mismatch: expected %0d, actual %0d",
                             $time, want.num, byte_number);
                end
                if (last_byte !== want.last_flag)
                begin
                    error_count++;
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, want.last_flag, last_byte);
                end
            end
        end
    end

    // Output stall: random at the current rate, or a long hold when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    // Power-up contents of the display state.
    task automatic init_display_model();
        model_point = POINT_RESET;
        model_scan  = 3'd0;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int k = 0; k < DIGITS; k++)
                model_text[r][k] = (k < TEXT_BYTES) ? power_up[r][k] : 8'h00;
            model_len[r] = 3'((DIGITS < TEXT_BYTES) ? DIGITS : TEXT_BYTES);
        end
    endtask

    // Pack a string into the text field, string index k in byte k.
    function automatic logic [47:0] pack_text(input string s);
        logic [47:0] packed_text;
        packed_text = '0;
        for (int k = 0; k < TEXT_BYTES && k < s.len(); k++)
            packed_text[8*k +: 8] = s[k];
        return packed_text;
    endfunction

    // Mostly displayable characters, sometimes any byte at all.
    function automatic logic [47:0] random_text();
        logic [47:0] t;
        for (int k = 0; k < TEXT_BYTES; k++)
        begin
            if ($urandom_range(99) < 80)
                t[8*k +: 8] = charset[$urandom_range(charset.len() - 1)];
            else
                t[8*k +: 8] = 8'($urandom_range(255));
        end
        return t;
    endfunction

    function automatic logic [2:0] random_length();
        if ($urandom_range(99) < 85)
            return 3'($urandom_range(1, DIGITS));
        return $urandom_range(1) ? 3'd0 : 3'd7;
    endfunction

    // Offer one item after an optional random gap; return at its transfer edge.
    task automatic send_item(input logic cmd, input logic [1:0] r,
                             input logic [2:0] len, input logic [47:0] txt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        row         <= r;
        text_length <= len;
        text        <= txt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // A tick carries random values in the fields it ignores.
    task automatic send_tick();
        send_item(CMD_TICK, 2'($urandom_range(3)), 3'($urandom_range(7)),
                  48'({$urandom(), $urandom()}));
    endtask

    // Wait until every pending frame byte has arrived and the block is quiet.
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_frame_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the point position register; only called while the block is idle.
    task automatic write_point(input logic [2:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_point = value;
    endtask

    // Power-up text on every digit position and the wrap back to position zero.
    task automatic test_power_up_text();
        repeat (DIGITS + 1) send_tick();
    endtask

    // Every displayable letter, an overlong length and a decimal point.
    task automatic test_character_set();
        drain_frames();
        write_point(3'd2);
        send_item(CMD_WRITE, 2'd0, 3'd6, pack_text("LTOASH"));
        send_item(CMD_WRITE, 2'd1, 3'd6, pack_text("IFGPCE"));
        send_item(CMD_WRITE, 2'd2, 3'd7, pack_text("UNRD.9"));
        repeat (DIGITS) send_tick();
    endtask

    // Empty row, short row, NUL and unknown bytes, and a write to a missing row.
    task automatic test_edge_fields();
        drain_frames();
        write_point(3'd1);
        send_item(CMD_WRITE, 2'd0, 3'd0, 48'hFFFF_FFFF_FFFF);
        send_item(CMD_WRITE, 2'd1, 3'd2, pack_text("78"));
        send_item(CMD_WRITE, 2'd2, 3'd6, 48'd0);
        send_item(CMD_WRITE, 2'd3, 3'd6, pack_text("888888"));
        repeat (3) send_tick();
    endtask

    // Random traffic in two halves, each under its own point position.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [2:0] first_point, input int items);
        int done;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int half = 0; half < 2; half++)
        begin
            drain_frames();
            write_point((half == 0) ? first_point : 3'($urandom_range(7)));
            done = 0;
            while (done < items / 2)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                begin
                    send_tick();
                    done++;
                end
                else if (pick < 95)
                begin
                    send_item(CMD_WRITE, 2'($urandom_range(ROWS - 1)), random_length(),
                              random_text());
                    done++;
                end
                else
                begin
                    // Writes to the missing row are ignored and not counted.
                    send_item(CMD_WRITE, 2'd3, random_length(), random_text());
                end
            end
        end
    endtask

    // A long output hold while ticks keep coming, so the input side must stall.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_frames();
        write_point(3'd3);
        @(negedge clk);
        hold_requests++;
        @(posedge clk);
        for (int i = 0; i < 24; i++)
        begin
            if (i % 4 == 3)
                send_item(CMD_WRITE, 2'($urandom_range(ROWS - 1)), random_length(),
                          random_text());
            else
                send_tick();
        end
    endtask

    initial
    begin
        init_display_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_text();
        test_character_set();
        test_edge_fields();
        test_random_traffic(0, 0, 3'd0, 70);
        test_random_traffic(81, 0, 3'd7, 70);
        test_random_traffic(0, 81, 3'd5, 70);
        test_random_traffic(33, 33, 3'd6, 70);
        test_output_backpressure();

        drain_frames();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d scan ticks and %0d row writes; checked %0d frame bytes",
                 ticks_sent, writes_sent, bytes_checked);
        $display("Covered idle and stall mixes, several point positions and a long output hold");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
